// ===== hdl/mbsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbsr_pkg;

  localparam int NumBufsDefault    = 8;
  localparam int BufDepthDefault   = 256;
  localparam int SampleBitsDefault = 16;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 9;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_BUF_LEN           = 2'd0,
    REG_RING_SIZE         = 2'd1,
    REG_AUTO_FIRST_ROTATE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_type_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic step;
    logic load_direct;
    logic load_mem;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic reinit;
    logic clear_done;
    logic read_hit;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/multi_buffer_sample_ring_unit.sv =====
// Channel  Direction  Handshake                 Payload
// cfg      in         cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
// in       in         in_valid_i, in_stall_o    req_type_i, write_data_i, force_write_i
// out      out        out_valid_o, out_stall_i  ok_o, read_data_o, full_buffers_o, rotated_o
//
// A write or a refused request is answered directly; a read that returns data
// also waits for the registered read of the sample store.
// After reset, and after each write of the buffer size or ring size register, the store
// is swept to zero one entry a cycle over all its entries, during which no item is
// taken. Configuration writes are taken at any time.
// A new item is taken while the previous result waits, as long as no read is waiting for
// the store and that result is being drained or the output register is empty.
`timescale 1ns / 1ps
`default_nettype none

module multi_buffer_sample_ring_unit #(
  parameter int NUM_BUFS    = mbsr_pkg::NumBufsDefault,
  parameter int BUF_DEPTH   = mbsr_pkg::BufDepthDefault,
  parameter int SAMPLE_BITS = mbsr_pkg::SampleBitsDefault
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [mbsr_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [mbsr_pkg::CfgDataWidth-1:0]  cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               req_type_i,
  input  wire logic signed [15:0]                 write_data_i,
  input  wire logic                               force_write_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    ok_o,
  output logic signed [15:0]                      read_data_o,
  output logic [3:0]                              full_buffers_o,
  output logic                                    rotated_o
);

  mbsr_pkg::dp_cmd_t    cmd;
  mbsr_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  mbsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  mbsr_dp #(
    .NUM_BUFS    (NUM_BUFS),
    .BUF_DEPTH   (BUF_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .write_data_i   (write_data_i),
    .force_write_i  (force_write_i),
    .ok_o           (ok_o),
    .read_data_o    (read_data_o),
    .full_buffers_o (full_buffers_o),
    .rotated_o      (rotated_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

`default_nettype wire

// ===== hdl/mbsr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbsr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output mbsr_pkg::dp_cmd_t         cmd_o,
  input  wire mbsr_pkg::dp_status_t status_i
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_RD    = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   accept;

  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o.clear_en    = (state_q == S_CLEAR);
    cmd_o.step        = accept;
    cmd_o.load_direct = accept && !status_i.read_hit;
    cmd_o.load_mem    = (state_q == S_RD) && out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (status_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && status_i.read_hit) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
    // A change of buffer or ring size restarts the clearing pass.
    if (status_i.reinit) begin
      state_d = S_CLEAR;
    end
  end

  always_comb begin
    if (cmd_o.load_direct || cmd_o.load_mem) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_read_waits_memory : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_i.read_hit && !status_i.reinit) |=> (state_q == S_RD))
    else $error("read hit did not enter the memory wait state");

  a_reinit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.reinit |=> (state_q == S_CLEAR))
    else $error("size change did not restart the clearing pass");

  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result was dropped");

endmodule

`default_nettype wire

// ===== hdl/mbsr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbsr_dp #(
  parameter int NUM_BUFS    = mbsr_pkg::NumBufsDefault,
  parameter int BUF_DEPTH   = mbsr_pkg::BufDepthDefault,
  parameter int SAMPLE_BITS = mbsr_pkg::SampleBitsDefault
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [mbsr_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  wire logic [mbsr_pkg::CfgDataWidth-1:0]     cfg_data_i,
  input  wire logic                                  req_type_i,
  input  wire logic signed [15:0]                    write_data_i,
  input  wire logic                                  force_write_i,
  output logic                                       ok_o,
  output logic signed [15:0]                         read_data_o,
  output logic [3:0]                                 full_buffers_o,
  output logic                                       rotated_o,
  input  wire mbsr_pkg::dp_cmd_t                     cmd_i,
  output mbsr_pkg::dp_status_t                       status_o
);

  localparam int BI_W      = $clog2(NUM_BUFS);
  localparam int RING_W    = $clog2(NUM_BUFS + 1);
  localparam int OFF_W     = $clog2(BUF_DEPTH);
  localparam int LEN_W     = $clog2(BUF_DEPTH + 1);
  localparam int ADDR_W    = BI_W + OFF_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int LEN_RST   = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;
  localparam int RING_RST  = (NUM_BUFS < 4) ? NUM_BUFS : 4;

  // Configuration, held in clamped form.
  logic [LEN_W-1:0]  len_q, len_d, len_cl;
  logic [RING_W-1:0] ring_q, ring_d, ring_cl;
  logic              afr_q;
  logic              wr_len, wr_ring, reinit;

  // Ring pointers. Fill is counted in whole buffers.
  logic [BI_W-1:0]   wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic [BI_W-1:0]   wr_idx_nx, rd_idx_nx;
  logic [OFF_W-1:0]  wr_off_q, wr_off_d, rd_off_q, rd_off_d;
  logic [RING_W-1:0] fill_q, fill_d;
  logic              first_done_q, first_done_d;
  logic [ADDR_W-1:0] clr_q, clr_d;

  logic is_read, writable, wr_ok, wr_last, rd_ok, rd_last;
  logic res_ok, res_rot;

  logic [SAMPLE_BITS-1:0] mem [MEM_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_q, sample_in, mem_wdata;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic                   mem_we, mem_re;
  logic [15:0]            rd_word;

  logic              ok_q, rot_q, pend_ok_q, pend_rot_q;
  logic [15:0]       read_data_q;
  logic [3:0]        full_q, pend_full_q;

  // Register writes and clamping.
  always_comb begin
    if (cfg_data_i < 9'd2) begin
      len_cl = LEN_W'(2);
    end else if (32'(cfg_data_i) > BUF_DEPTH) begin
      len_cl = LEN_W'(BUF_DEPTH);
    end else begin
      len_cl = LEN_W'(cfg_data_i);
    end
    if (cfg_data_i[3:0] < 4'd2) begin
      ring_cl = RING_W'(2);
    end else if (32'(cfg_data_i[3:0]) > NUM_BUFS) begin
      ring_cl = RING_W'(NUM_BUFS);
    end else begin
      ring_cl = RING_W'(cfg_data_i[3:0]);
    end
  end

  assign wr_len  = cfg_we_i && (cfg_index_i == mbsr_pkg::REG_BUF_LEN);
  assign wr_ring = cfg_we_i && (cfg_index_i == mbsr_pkg::REG_RING_SIZE);
  assign reinit  = wr_len || wr_ring;
  assign len_d   = wr_len ? len_cl : len_q;
  assign ring_d  = wr_ring ? ring_cl : ring_q;

  // Request decode.
  assign is_read   = (req_type_i == mbsr_pkg::REQ_READ);
  assign writable  = (rd_idx_q != wr_idx_q) && (fill_q < (ring_q - RING_W'(1)));
  assign wr_ok     = !is_read && (writable || force_write_i);
  assign wr_last   = (LEN_W'(wr_off_q) + LEN_W'(1)) == len_q;
  assign rd_ok     = is_read && (fill_q != '0);
  assign rd_last   = (LEN_W'(rd_off_q) + LEN_W'(1)) == len_q;
  assign wr_idx_nx = ((RING_W'(wr_idx_q) + RING_W'(1)) == ring_q) ? '0 : wr_idx_q + BI_W'(1);
  assign rd_idx_nx = ((RING_W'(rd_idx_q) + RING_W'(1)) == ring_q) ? '0 : rd_idx_q + BI_W'(1);
  assign res_ok    = wr_ok || rd_ok;
  assign res_rot   = (wr_ok && wr_last) || (rd_ok && rd_last);

  always_comb begin
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    wr_off_d     = wr_off_q;
    rd_off_d     = rd_off_q;
    fill_d       = fill_q;
    first_done_d = first_done_q;
    clr_d        = clr_q;
    if (reinit) begin
      wr_idx_d     = '0;
      rd_idx_d     = BI_W'(ring_d - RING_W'(1));
      wr_off_d     = '0;
      rd_off_d     = '0;
      fill_d       = '0;
      first_done_d = 1'b0;
      clr_d        = '0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_d = clr_q + ADDR_W'(1);
      end
      if (cmd_i.step && wr_ok) begin
        if (wr_last) begin
          wr_idx_d = wr_idx_nx;
          wr_off_d = '0;
          fill_d   = (fill_q == ring_q) ? ring_q : fill_q + RING_W'(1);
          if (afr_q && !first_done_q) begin
            first_done_d = 1'b1;
            rd_idx_d     = rd_idx_nx;
          end
        end else begin
          wr_off_d = wr_off_q + OFF_W'(1);
        end
      end
      if (cmd_i.step && rd_ok) begin
        if (rd_last) begin
          rd_idx_d = rd_idx_nx;
          rd_off_d = '0;
          fill_d   = fill_q - RING_W'(1);
        end else begin
          rd_off_d = rd_off_q + OFF_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= LEN_W'(LEN_RST);
      ring_q       <= RING_W'(RING_RST);
      afr_q        <= 1'b1;
      wr_idx_q     <= '0;
      rd_idx_q     <= BI_W'(RING_RST - 1);
      wr_off_q     <= '0;
      rd_off_q     <= '0;
      fill_q       <= '0;
      first_done_q <= 1'b0;
      clr_q        <= '0;
    end else begin
      len_q        <= len_d;
      ring_q       <= ring_d;
      if (cfg_we_i && (cfg_index_i == mbsr_pkg::REG_AUTO_FIRST_ROTATE)) begin
        afr_q <= cfg_data_i[0];
      end
      wr_idx_q     <= wr_idx_d;
      rd_idx_q     <= rd_idx_d;
      wr_off_q     <= wr_off_d;
      rd_off_q     <= rd_off_d;
      fill_q       <= fill_d;
      first_done_q <= first_done_d;
      clr_q        <= clr_d;
    end
  end

  // Sample width adaptation between the 16-bit ports and the store.
  generate
    if (SAMPLE_BITS > 16) begin : g_wide
      assign sample_in = {{(SAMPLE_BITS - 16){write_data_i[15]}}, write_data_i};
      assign rd_word   = rdata_q[15:0];
    end else if (SAMPLE_BITS == 16) begin : g_same
      assign sample_in = write_data_i;
      assign rd_word   = rdata_q;
    end else begin : g_narrow
      assign sample_in = write_data_i[SAMPLE_BITS-1:0];
      assign rd_word   = {{(16 - SAMPLE_BITS){1'b0}}, rdata_q};
    end
  endgenerate

  // Sample store: one write port, shared with the clearing pass, and one read port.
  assign mem_we    = cmd_i.clear_en || (cmd_i.step && wr_ok);
  assign mem_waddr = cmd_i.clear_en ? clr_q : {wr_idx_q, wr_off_q};
  assign mem_wdata = cmd_i.clear_en ? '0 : sample_in;
  assign mem_re    = cmd_i.step && rd_ok;
  assign mem_raddr = {rd_idx_q, rd_off_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Result register. A read that hits is held pending until the registered store read is loaded.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pend_ok_q   <= res_ok;
      pend_rot_q  <= res_rot;
      pend_full_q <= 4'(fill_d);
    end
    if (cmd_i.load_direct) begin
      ok_q        <= res_ok;
      rot_q       <= res_rot;
      full_q      <= 4'(fill_d);
      read_data_q <= '0;
    end else if (cmd_i.load_mem) begin
      ok_q        <= pend_ok_q;
      rot_q       <= pend_rot_q;
      full_q      <= pend_full_q;
      read_data_q <= rd_word;
    end
  end

  assign ok_o           = ok_q;
  assign rotated_o      = rot_q;
  assign full_buffers_o = full_q;
  assign read_data_o    = read_data_q;

  assign status_o.reinit     = reinit;
  assign status_o.clear_done = &clr_q;
  assign status_o.read_hit   = rd_ok;

  a_fill_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ring_q)
    else $error("fill exceeds the ring length");

  a_wr_idx_in_ring : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (RING_W'(wr_idx_q) < ring_q) && (RING_W'(rd_idx_q) < ring_q))
    else $error("buffer index outside the ring");

  a_offsets_in_buffer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LEN_W'(wr_off_q) < len_q) && (LEN_W'(rd_off_q) < len_q))
    else $error("offset beyond the buffer length");

endmodule

`default_nettype wire
